// ===== hdl/clss_pkg.sv =====
// ---------------------------------------------------------------------------
// clss_pkg: shared types and codes for the cyclic lattice species step
// Outcome codes, command codes and the controller-to-datapath command struct.
// ---------------------------------------------------------------------------
package clss_pkg;

    localparam logic [2:0] OUT_EMPTY   = 3'd0;
    localparam logic [2:0] OUT_NONE    = 3'd1;
    localparam logic [2:0] OUT_REPRO   = 3'd2;
    localparam logic [2:0] OUT_PREDATE = 3'd3;
    localparam logic [2:0] OUT_MOVE    = 3'd4;
    localparam logic [2:0] OUT_WRITTEN = 3'd5;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_INTERACT = 1'b1;

    localparam logic [1:0] REG_REPRO = 2'd0;
    localparam logic [1:0] REG_PRED  = 2'd1;
    localparam logic [1:0] REG_WK1   = 2'd2;
    localparam logic [1:0] REG_WK3   = 2'd3;

    localparam logic [16:0] FULL_SCALE = 17'd65536;
    localparam logic [16:0] CNT_MAX    = 17'h1FFFF;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input word, issue reads
        logic exec;     // read data valid: compute and write back
        logic pop;      // result word taken
    } clss_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic busy_clear;  // clearing pass running
    } clss_stat_t;

endpackage

// ===== hdl/clss_ctrl.sv =====
// ---------------------------------------------------------------------------
// clss_ctrl: sequencer for the lattice step
// Load, execute, hold result; handshakes for both channels.
// ---------------------------------------------------------------------------
module clss_ctrl
    import clss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  clss_stat_t stat,
    output clss_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // one result at a time: next word waits until the result is taken
    assign s_ready = (state_reg == ST_IDLE) && !stat.busy_clear;
    assign m_valid = (state_reg == ST_HOLD);

    always_comb begin
        cmd.load  = s_valid && s_ready;
        cmd.exec  = (state_reg == ST_EXEC);
        cmd.pop   = m_valid && m_ready;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd.load) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_HOLD;
            ST_HOLD: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg)) else $error("state not one-hot");
    a_load_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec) else $error("load not followed by exec");
    a_exec_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid) else $error("exec not followed by result");
`endif

endmodule

// ===== hdl/clss_datapath.sv =====
// ---------------------------------------------------------------------------
// clss_datapath: lattice memory, counters and interaction logic
// Two-port lattice RAM, clearing pass after reset, count registers.
// ---------------------------------------------------------------------------
module clss_datapath
    import clss_pkg::*;
#(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  clss_cmd_t   cmd,
    output clss_stat_t  stat,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_command,
    input  logic [7:0]  s_col,
    input  logic [7:0]  s_row,
    input  logic [2:0]  s_direction,
    input  logic [15:0] s_action_draw,
    input  logic [15:0] s_weakness_draw,
    input  logic [2:0]  s_site_value,
    output logic [2:0]  m_outcome,
    output logic        m_generation_mark,
    output logic [16:0] m_count [5],
    output logic [16:0] m_preyed [5]
);

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW:0] DEPTH_W = AW'(0) + (AW+1)'(DEPTH);

    // configuration
    logic [16:0] repro_reg, pred_reg, wk1_reg, wk3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repro_reg <= 17'd13107;
            pred_reg  <= 17'd13107;
            wk1_reg   <= FULL_SCALE;
            wk3_reg   <= FULL_SCALE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_REPRO: repro_reg <= cfg_data;
                REG_PRED:  pred_reg  <= cfg_data;
                REG_WK1:   wk1_reg   <= cfg_data;
                REG_WK3:   wk3_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    // site reduction: constant lookup on the 8-bit coordinate
    logic [CW-1:0] col_tab [256];
    logic [RW-1:0] row_tab [256];
    always_comb begin
        for (int i = 0; i < 256; i++) begin
            col_tab[i] = CW'(i % GRID_COLS);
            row_tab[i] = RW'(i % GRID_ROWS);
        end
    end

    logic [CW-1:0] c_in, rt, lf, pc;
    logic [RW-1:0] r_in, up, dn, pr;
    assign c_in = col_tab[s_col];
    assign r_in = row_tab[s_row];
    assign rt = (c_in == CW'(GRID_COLS - 1)) ? '0 : c_in + 1'b1;
    assign lf = (c_in == '0) ? CW'(GRID_COLS - 1) : c_in - 1'b1;
    assign up = (r_in == RW'(GRID_ROWS - 1)) ? '0 : r_in + 1'b1;
    assign dn = (r_in == '0) ? RW'(GRID_ROWS - 1) : r_in - 1'b1;

    always_comb begin
        pr = r_in;
        pc = c_in;
        unique case (s_direction)
            3'd0: pr = up;
            3'd1: pr = dn;
            3'd2: pc = rt;
            3'd3: pc = lf;
            3'd4: begin pr = up; pc = rt; end
            3'd5: begin pr = dn; pc = lf; end
            3'd6: begin pr = up; pc = lf; end
            default: begin pr = dn; pc = rt; end
        endcase
    end

    logic [AW-1:0] here_addr, there_addr;
    assign here_addr  = AW'(r_in * GRID_COLS + c_in);
    assign there_addr = AW'(pr * GRID_COLS + pc);

    // captured word
    logic          cmd_reg;
    logic [AW-1:0] here_reg, there_reg;
    logic [15:0]   act_reg, weak_reg;
    logic [2:0]    val_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= s_command;
            here_reg  <= here_addr;
            there_reg <= there_addr;
            act_reg   <= s_action_draw;
            weak_reg  <= s_weakness_draw;
            val_reg   <= (s_site_value > 3'd5) ? 3'd0 : s_site_value;
        end
    end

    // lattice memory, two ports; clearing pass uses port A
    logic [2:0]    lattice [DEPTH];
    logic [2:0]    rd_a, rd_b;
    logic          wa_en, wb_en;
    logic [AW-1:0] wa_addr;
    logic [2:0]    wa_data, wb_data;
    logic          clr_reg;
    logic [AW:0]   clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (wa_en) lattice[wa_addr] <= wa_data;
        if (wb_en) lattice[there_reg] <= wb_data;
        if (cmd.load) begin
            rd_a <= lattice[here_addr];
            rd_b <= lattice[there_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end else if (clr_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == DEPTH_W - 1'b1) clr_reg <= 1'b0;
        end
    end
    assign stat.busy_clear = clr_reg;

    // counters
    logic [16:0] cnt_reg [5];
    logic [16:0] prey_reg [5];
    logic [AW-1:0] succ_reg;
    logic [2:0]  outcome_reg;
    logic        mark_reg;

    logic [16:0] pa, lim;
    logic [17:0] sum;
    assign pa  = (repro_reg > FULL_SCALE) ? FULL_SCALE : repro_reg;
    assign sum = {1'b0, pa} + {1'b0, (pred_reg > FULL_SCALE) ? FULL_SCALE : pred_reg};
    assign lim = (sum > {1'b0, FULL_SCALE}) ? FULL_SCALE : sum[16:0];

    logic [2:0] s, prey, oc, inc_sp, dec_sp;
    logic       gate, inc_en, dec_en, pinc_en;

    always_comb begin
        s      = rd_a;
        prey   = (s == 3'd5) ? 3'd1 : s + 3'd1;
        gate   = (s == 3'd1) ? ({1'b0, weak_reg} < wk1_reg) :
                 (s == 3'd3) ? ({1'b0, weak_reg} < wk3_reg) : 1'b1;
        oc      = OUT_NONE;
        wa_en   = 1'b0;
        wb_en   = 1'b0;
        wa_addr = here_reg;
        wa_data = val_reg;
        wb_data = s;
        inc_en  = 1'b0;
        dec_en  = 1'b0;
        pinc_en = 1'b0;
        inc_sp  = s;
        dec_sp  = prey;
        if (clr_reg) begin
            wa_en   = 1'b1;
            wa_addr = clr_cnt_reg[AW-1:0];
            wa_data = 3'd0;
        end else if (cmd.exec) begin
            if (cmd_reg == CMD_WRITE) begin
                oc     = OUT_WRITTEN;
                wa_en  = 1'b1;
                dec_en = (rd_a != 3'd0);
                dec_sp = rd_a;
                inc_en = (val_reg != 3'd0);
                inc_sp = val_reg;
            end else if (s == 3'd0) begin
                oc = OUT_EMPTY;
            end else if ({1'b0, act_reg} < pa) begin
                if (rd_b == 3'd0) begin
                    oc     = OUT_REPRO;
                    wb_en  = 1'b1;
                    inc_en = 1'b1;
                end
            end else if ({1'b0, act_reg} < lim) begin
                if (gate && rd_b == prey) begin
                    oc      = OUT_PREDATE;
                    wb_en   = 1'b1;
                    wb_data = 3'd0;
                    dec_en  = 1'b1;
                    pinc_en = 1'b1;
                end
            end else begin
                oc      = OUT_MOVE;
                wb_en   = 1'b1;
                wa_en   = (here_reg != there_reg);
                wa_data = rd_b;
            end
        end
    end

    logic succ, wrap;
    assign succ = cmd.exec && cmd_reg == CMD_INTERACT &&
                  (oc == OUT_REPRO || oc == OUT_PREDATE || oc == OUT_MOVE);
    assign wrap = succ && ({1'b0, succ_reg} == DEPTH_W - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) begin
                cnt_reg[i]  <= '0;
                prey_reg[i] <= '0;
            end
            succ_reg <= '0;
            mark_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                for (int i = 0; i < 5; i++) begin
                    logic [16:0] v;
                    v = cnt_reg[i];
                    if (dec_en && dec_sp == 3'(i + 1) && v != '0) v = v - 1'b1;
                    if (inc_en && inc_sp == 3'(i + 1) && v != CNT_MAX) v = v + 1'b1;
                    cnt_reg[i] <= v;
                    if (pinc_en && prey == 3'(i + 1) && prey_reg[i] != CNT_MAX)
                        prey_reg[i] <= prey_reg[i] + 1'b1;
                end
                mark_reg <= wrap;
                if (succ) succ_reg <= wrap ? '0 : succ_reg + 1'b1;
            end
            if (cmd.pop && mark_reg) begin
                for (int i = 0; i < 5; i++) prey_reg[i] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) outcome_reg <= oc;
    end

    assign m_outcome         = outcome_reg;
    assign m_generation_mark = mark_reg;
    assign m_count           = cnt_reg;
    assign m_preyed          = prey_reg;

`ifndef SYNTHESIS
    a_no_load_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_reg |-> !cmd.load) else $error("word taken during clear");
    a_write_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && cmd_reg == CMD_WRITE) |=> !mark_reg) else $error("mark on write");
    a_succ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, succ_reg} < DEPTH_W)) else $error("success counter out of range");
`endif

endmodule

// ===== hdl/cyclic_lattice_species_step.sv =====
// ---------------------------------------------------------------------------
// cyclic_lattice_species_step: five-species cyclic lattice Monte Carlo step
// Write or interact on a toroidal lattice, reporting species and prey counts.
// ---------------------------------------------------------------------------
//  channel | handshake            | payload
//  s_      | s_valid / s_ready    | command col row direction draws site_value
//  m_      | m_valid / m_ready    | outcome generation_mark count_* preyed_*
//  cfg     | cfg_we               | cfg_index cfg_data
//
// Each word passes three steps: accept (lattice reads issued), execute
// (sites written back through the two RAM ports), result held until taken.
// After reset a clearing pass empties the lattice; s_ready stays low meanwhile,
// config writes are still taken. A stalled result blocks the next word; payload
// holds while m_valid is high.
// ---------------------------------------------------------------------------
module cyclic_lattice_species_step
    import clss_pkg::*;
#(
    parameter int GRID_COLS = 256,
    parameter int GRID_ROWS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_col,
    input  logic [7:0]  s_row,
    input  logic [2:0]  s_direction,
    input  logic [15:0] s_action_draw,
    input  logic [15:0] s_weakness_draw,
    input  logic [2:0]  s_site_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_outcome,
    output logic        m_generation_mark,
    output logic [16:0] m_count_one,
    output logic [16:0] m_count_two,
    output logic [16:0] m_count_three,
    output logic [16:0] m_count_four,
    output logic [16:0] m_count_five,
    output logic [16:0] m_preyed_one,
    output logic [16:0] m_preyed_two,
    output logic [16:0] m_preyed_three,
    output logic [16:0] m_preyed_four,
    output logic [16:0] m_preyed_five
);

    clss_cmd_t   cmd;
    clss_stat_t  stat;
    logic [16:0] cnt [5];
    logic [16:0] prey [5];

    clss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    clss_datapath #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_command         (s_command),
        .s_col             (s_col),
        .s_row             (s_row),
        .s_direction       (s_direction),
        .s_action_draw     (s_action_draw),
        .s_weakness_draw   (s_weakness_draw),
        .s_site_value      (s_site_value),
        .m_outcome         (m_outcome),
        .m_generation_mark (m_generation_mark),
        .m_count           (cnt),
        .m_preyed          (prey)
    );

    assign m_count_one    = cnt[0];
    assign m_count_two    = cnt[1];
    assign m_count_three  = cnt[2];
    assign m_count_four   = cnt[3];
    assign m_count_five   = cnt[4];
    assign m_preyed_one   = prey[0];
    assign m_preyed_two   = prey[1];
    assign m_preyed_three = prey[2];
    assign m_preyed_four  = prey[3];
    assign m_preyed_five  = prey[4];

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: testbench for cyclic_lattice_species_step
// Drives site writes and interactions with random idling on both channels,
// predicts each result word from a behavioral lattice model and checks it.
// ---------------------------------------------------------------------------
module tb;
    import clss_pkg::*;

    localparam int COLS = 256;
    localparam int ROWS = 256;
    localparam int SITES = COLS * ROWS;

    typedef struct {
        logic [2:0]  outcome;
        logic        mark;
        logic [16:0] counts [5];
        logic [16:0] preyed [5];
    } step_word_t;

    // Lattice model plus the expected-result queue.
    class lattice_scoreboard;
        logic [2:0]  grid [SITES];
        logic [16:0] pop_cnt [5];
        logic [16:0] prey_cnt [5];
        logic [15:0] wins;
        logic [16:0] pa_reg, pc_reg, wk1_reg, wk3_reg;
        step_word_t  pending [$];
        int          errors;

        function new();
            foreach (grid[i]) grid[i] = 3'd0;
            for (int k = 0; k < 5; k++) begin
                pop_cnt[k] = '0;
                prey_cnt[k] = '0;
            end
            wins = '0;
            pa_reg = 17'd13107;
            pc_reg = 17'd13107;
            wk1_reg = FULL_SCALE;
            wk3_reg = FULL_SCALE;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] v);
            case (idx)
                REG_REPRO: pa_reg = v;
                REG_PRED:  pc_reg = v;
                REG_WK1:   wk1_reg = v;
                default:   wk3_reg = v;
            endcase
        endfunction

        function void bump(ref logic [16:0] c);
            if (c != CNT_MAX) c++;
        endfunction

        function void drop(ref logic [16:0] c);
            if (c != '0) c--;
        endfunction

        function void note_word(logic cmd, logic [7:0] c, logic [7:0] r, logic [2:0] dir,
                                logic [15:0] act, logic [15:0] wd, logic [2:0] val);
            step_word_t w;
            int here, there, pr, pcl;
            logic [2:0] s, prey, t;
            logic [16:0] pa;
            logic [17:0] lim;
            logic gate;
            here = int'(r) * COLS + int'(c);
            w.outcome = OUT_NONE;
            w.mark = 1'b0;
            if (cmd == CMD_WRITE) begin
                if (val > 3'd5) val = 3'd0;
                if (grid[here] != 3'd0) drop(pop_cnt[int'(grid[here]) - 1]);
                if (val != 3'd0) bump(pop_cnt[int'(val) - 1]);
                grid[here] = val;
                w.outcome = OUT_WRITTEN;
            end else if (grid[here] == 3'd0) begin
                w.outcome = OUT_EMPTY;
            end else begin
                s = grid[here];
                pr = int'(r);
                pcl = int'(c);
                // directions 0, 4 and 6 step row up, 1, 5 and 7 down; east/west by table
                case (dir)
                    3'd0: pr = int'(r) + 1;
                    3'd1: pr = int'(r) - 1;
                    3'd2: pcl = int'(c) + 1;
                    3'd3: pcl = int'(c) - 1;
                    3'd4: begin pr = int'(r) + 1; pcl = int'(c) + 1; end
                    3'd5: begin pr = int'(r) - 1; pcl = int'(c) - 1; end
                    3'd6: begin pr = int'(r) + 1; pcl = int'(c) - 1; end
                    default: begin pr = int'(r) - 1; pcl = int'(c) + 1; end
                endcase
                pr = (pr + ROWS) % ROWS;
                pcl = (pcl + COLS) % COLS;
                there = pr * COLS + pcl;
                pa = (pa_reg > FULL_SCALE) ? FULL_SCALE : pa_reg;
                lim = {1'b0, pa} + {1'b0, (pc_reg > FULL_SCALE) ? FULL_SCALE : pc_reg};
                if (lim > {1'b0, FULL_SCALE}) lim = {1'b0, FULL_SCALE};
                if ({1'b0, act} < pa) begin
                    if (grid[there] == 3'd0) begin
                        grid[there] = s;
                        bump(pop_cnt[int'(s) - 1]);
                        w.outcome = OUT_REPRO;
                    end
                end else if ({2'b0, act} < lim) begin
                    prey = (s == 3'd5) ? 3'd1 : s + 3'd1;
                    gate = 1'b1;
                    if (s == 3'd1) gate = {1'b0, wd} < wk1_reg;
                    else if (s == 3'd3) gate = {1'b0, wd} < wk3_reg;
                    if (gate && grid[there] == prey) begin
                        grid[there] = 3'd0;
                        drop(pop_cnt[int'(prey) - 1]);
                        bump(prey_cnt[int'(prey) - 1]);
                        w.outcome = OUT_PREDATE;
                    end
                end else begin
                    t = grid[there];
                    grid[there] = grid[here];
                    grid[here] = t;
                    w.outcome = OUT_MOVE;
                end
                if (w.outcome != OUT_NONE) begin
                    wins++;
                    w.mark = (wins == '0);  // 16-bit wrap = one generation
                end
            end
            w.counts = pop_cnt;
            w.preyed = prey_cnt;
            if (w.mark)
                for (int k = 0; k < 5; k++) prey_cnt[k] = '0;
            pending.push_back(w);
        endfunction

        function void check_word(step_word_t got);
            step_word_t exp_w;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.outcome !== exp_w.outcome) begin
                $error("outcome exp %0d got %0d", exp_w.outcome, got.outcome);
                errors++;
            end
            if (got.mark !== exp_w.mark) begin
                $error("generation_mark exp %0d got %0d", exp_w.mark, got.mark);
                errors++;
            end
            for (int k = 0; k < 5; k++) begin
                if (got.counts[k] !== exp_w.counts[k]) begin
                    $error("count[%0d] exp %0d got %0d", k + 1, exp_w.counts[k],
                           got.counts[k]);
                    errors++;
                end
                if (got.preyed[k] !== exp_w.preyed[k]) begin
                    $error("preyed[%0d] exp %0d got %0d", k + 1, exp_w.preyed[k],
                           got.preyed[k]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_REPRO;
    logic [16:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = CMD_WRITE;
    logic [7:0]  s_col = '0, s_row = '0;
    logic [2:0]  s_direction = '0;
    logic [15:0] s_action_draw = '0, s_weakness_draw = '0;
    logic [2:0]  s_site_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_outcome;
    logic        m_generation_mark;
    logic [16:0] m_count_one, m_count_two, m_count_three, m_count_four, m_count_five;
    logic [16:0] m_preyed_one, m_preyed_two, m_preyed_three, m_preyed_four, m_preyed_five;

    lattice_scoreboard sb;
    bit quiet = 1'b0;   // hold m_ready high, no stalls

    cyclic_lattice_species_step #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) dut (.*);

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Result side: random stalls per word, sample at the rising edge.
    initial begin
        step_word_t got;
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            gap = quiet ? 0 : $urandom_range(0, 11);
            m_ready = 1'b0;
            repeat (gap) @(negedge aclk);
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.outcome = m_outcome;
            got.mark = m_generation_mark;
            got.counts = '{m_count_one, m_count_two, m_count_three, m_count_four,
                           m_count_five};
            got.preyed = '{m_preyed_one, m_preyed_two, m_preyed_three, m_preyed_four,
                           m_preyed_five};
            sb.check_word(got);
        end
    end

    // One input word; waits its own idle gap, then holds until accepted.
    // Valid stays high into the next word when that word has no gap.
    task automatic send_word(logic cmd, logic [7:0] c, logic [7:0] r, logic [2:0] dir,
                             logic [15:0] act, logic [15:0] wd, logic [2:0] val);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap != 0) s_valid <= 1'b0;
        repeat (gap) @(negedge aclk);
        s_valid <= 1'b1;
        s_command <= cmd;
        s_col <= c;
        s_row <= r;
        s_direction <= dir;
        s_action_draw <= act;
        s_weakness_draw <= wd;
        s_site_value <= val;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(cmd, c, r, dir, act, wd, val);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
        @(negedge aclk);
    endtask

    // Config only while idle: drain expectations, then a few spare cycles.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Random content on a small patch so interactions meet populated sites.
    task automatic random_word(int patch);
        logic [7:0] c, r;
        c = 8'($urandom_range(0, patch));
        r = 8'($urandom_range(0, patch));
        if ($urandom_range(0, 3) == 0)
            send_word(CMD_WRITE, c, r, 3'($urandom), 16'($urandom), 16'($urandom),
                      3'($urandom_range(0, 7)));
        else
            send_word(CMD_INTERACT, c, r, 3'($urandom), 16'($urandom), 16'($urandom),
                      3'($urandom));
    endtask

    initial begin
        logic [16:0] pa_set [4];
        logic [16:0] pc_set [4];
        logic [16:0] wk_set [4];
        sb = new();
        pa_set = '{17'd0, 17'd30000, 17'd65536, 17'd13107};
        pc_set = '{17'd65536, 17'd20000, 17'd0, 17'h1FFFF};
        wk_set = '{17'd0, 17'd32768, 17'h1FFFF, 17'd65536};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: writes at the extremes, invalid values, empty site, wraps.
        send_word(CMD_WRITE, 8'd255, 8'd255, 3'd0, 16'hFFFF, 16'hFFFF, 3'd1);
        send_word(CMD_WRITE, 8'd0, 8'd0, 3'd0, 16'h0, 16'h0, 3'd2);
        send_word(CMD_WRITE, 8'd1, 8'd0, 3'd0, 16'h0, 16'h0, 3'd7);
        send_word(CMD_WRITE, 8'd2, 8'd0, 3'd0, 16'h0, 16'h0, 3'd6);
        send_word(CMD_INTERACT, 8'd5, 8'd5, 3'd0, 16'h0, 16'h0, 3'd0);
        // reproduce across the torus corner, every direction
        for (int d = 0; d < 8; d++)
            send_word(CMD_INTERACT, 8'd255, 8'd255, d[2:0], 16'h0, 16'h0, 3'd0);
        // predation: species 2 eats 3, species 5 eats 1
        send_word(CMD_WRITE, 8'd0, 8'd1, 3'd0, 16'h0, 16'h0, 3'd3);
        send_word(CMD_INTERACT, 8'd0, 8'd0, 3'd0, 16'd20000, 16'h0, 3'd0);
        send_word(CMD_WRITE, 8'd10, 8'd10, 3'd0, 16'h0, 16'h0, 3'd5);
        send_word(CMD_WRITE, 8'd11, 8'd10, 3'd0, 16'h0, 16'h0, 3'd1);
        send_word(CMD_INTERACT, 8'd10, 8'd10, 3'd2, 16'd20000, 16'hFFFF, 3'd0);
        // move: top draw, swapping with a site of another species and back
        send_word(CMD_INTERACT, 8'd0, 8'd0, 3'd3, 16'hFFFF, 16'h0, 3'd0);
        send_word(CMD_INTERACT, 8'd255, 8'd0, 3'd2, 16'hFFFF, 16'h0, 3'd0);
        send_word(CMD_WRITE, 8'd255, 8'd255, 3'd0, 16'h0, 16'h0, 3'd0);

        // Random phases over register settings, extremes included.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            write_reg(REG_REPRO, pa_set[ph]);
            write_reg(REG_PRED, pc_set[ph]);
            write_reg(REG_WK1, wk_set[ph]);
            write_reg(REG_WK3, wk_set[3 - ph]);
            cfg_we <= 1'b0;
            quiet = (ph == 2);
            for (int i = 0; i < 210; i++) random_word(ph == 3 ? 255 : 7);
        end

        drain();
        repeat (20) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("PASS cyclic_lattice_species_step");
        else
            $display("FAIL cyclic_lattice_species_step");
        $finish;
    end

    // Timeout covers the clearing pass and ~900 words at worst-case stalls.
    initial begin
        #2000000;
        $display("FAIL cyclic_lattice_species_step");
        $finish;
    end
endmodule
